FILE: src/ipatf_pkg.sv
package ipatf_pkg;

  // queue between classifier and character sequencer
  localparam int QUEUE_DEPTH = 2;

  // number of units (groups or octets) per family
  localparam int V6_UNITS = 8;
  localparam int V4_UNITS = 4;

  // ascii codes
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_LOW_A = 7'h61;
  localparam logic [6:0] CHAR_DOT   = 7'h2e;
  localparam logic [6:0] CHAR_COLON = 7'h3a;

  // classified address, one unit per group (v6) or octet (v4)
  typedef struct packed {
    logic             is_v6;
    logic             has_run;
    logic [2:0]       run_start;
    logic [3:0]       run_end;
    logic [7:0][15:0] nib;
    logic [7:0][1:0]  top;
  } token_t;

endpackage

FILE: src/ip_address_text_formatter.sv
// ip address text formatter: one address in, its text out one character per cycle
// the address passes the queue, the sequencer and the output register
// throughput: one character per cycle while the receiver pops; a text has 7 to 15
//   characters for ipv4 and 2 to 39 for ipv6, and the rate is set by the single
//   character sequencer and its output register
// reset: synchronous, clears the queue, the sequencer and the output valid flag
module ip_address_text_formatter import ipatf_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  input  logic        is_v6,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  text_char,
  output logic        last_char
);

  token_t front_tok;
  token_t queue_tok;
  logic   queue_empty;
  logic   back_take;

  // classify the incoming address
  ipatf_front u_front (
    .addr_high (addr_high),
    .addr_low  (addr_low),
    .is_v6     (is_v6),
    .tok       (front_tok)
  );

  // decoupling queue
  ipatf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_tok),
    .full    (full),
    .rd_en   (back_take),
    .empty   (queue_empty),
    .rd_data (queue_tok)
  );

  // character sequencer
  ipatf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (!queue_empty),
    .tok_in    (queue_tok),
    .tok_take  (back_take),
    .empty     (empty),
    .pop       (pop),
    .text_char (text_char),
    .last_char (last_char)
  );

endmodule

FILE: src/ipatf_front.sv
module ipatf_front import ipatf_pkg::*; (
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  input  logic        is_v6,
  output token_t      tok
);

  // split an octet into hundreds, tens and ones
  function automatic logic [11:0] dec_split(input logic [7:0] v);
    logic [3:0] h;
    logic [3:0] t;
    logic [7:0] r;
    logic [7:0] r2;
    h = 4'd0;
    if (v >= 8'd200) begin
      h = 4'd2;
    end else if (v >= 8'd100) begin
      h = 4'd1;
    end
    r = v - 8'(h * 100);
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 8'(k * 10)) begin
        t = 4'(k);
      end
    end
    r2 = r - 8'(t * 10);
    return {h, t, r2[3:0]};
  endfunction

  logic [127:0]     full_addr;
  logic [7:0][15:0] grp;
  logic [7:0]       zero;
  logic [3:0]       cur_len;
  logic [2:0]       cur_start;
  logic [3:0]       best_len;
  logic [2:0]       best_start;

  assign full_addr = {addr_high, addr_low};

  // groups and zero flags
  always_comb begin
    for (int i = 0; i < V6_UNITS; i++) begin
      grp[i]  = full_addr[127 - 16 * i -: 16];
      zero[i] = (grp[i] == 16'd0);
    end
  end

  // longest zero run of two or more, first one on a tie
  always_comb begin
    cur_len    = 4'd0;
    cur_start  = 3'd0;
    best_len   = 4'd0;
    best_start = 3'd0;
    for (int i = 0; i < V6_UNITS; i++) begin
      if (zero[i]) begin
        if (cur_len == 4'd0) begin
          cur_start = 3'(i);
        end
        cur_len = cur_len + 4'd1;
        if (cur_len >= 4'd2 && cur_len > best_len) begin
          best_len   = cur_len;
          best_start = cur_start;
        end
      end else begin
        cur_len = 4'd0;
      end
    end
  end

  // build the token for either family
  always_comb begin
    logic [7:0]  oct;
    logic [11:0] dec;
    oct           = 8'd0;
    dec           = 12'd0;
    tok           = '0;
    tok.is_v6     = is_v6;
    tok.has_run   = is_v6 && (best_len != 4'd0);
    tok.run_start = best_start;
    tok.run_end   = {1'b0, best_start} + best_len;
    if (is_v6) begin
      for (int i = 0; i < V6_UNITS; i++) begin
        tok.nib[i] = grp[i];
        if (grp[i][15:12] != 4'd0) begin
          tok.top[i] = 2'd3;
        end else if (grp[i][11:8] != 4'd0) begin
          tok.top[i] = 2'd2;
        end else if (grp[i][7:4] != 4'd0) begin
          tok.top[i] = 2'd1;
        end else begin
          tok.top[i] = 2'd0;
        end
      end
    end else begin
      for (int k = 0; k < V4_UNITS; k++) begin
        oct        = addr_low[31 - 8 * k -: 8];
        dec        = dec_split(oct);
        tok.nib[k] = {4'd0, dec};
        if (oct >= 8'd100) begin
          tok.top[k] = 2'd2;
        end else if (oct >= 8'd10) begin
          tok.top[k] = 2'd1;
        end else begin
          tok.top[k] = 2'd0;
        end
      end
    end
  end

endmodule

FILE: src/ipatf_queue.sv
module ipatf_queue import ipatf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  token_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output logic   empty,
  output token_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/ipatf_back.sv
module ipatf_back import ipatf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       tok_valid,
  input  token_t     tok_in,
  output logic       tok_take,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] text_char,
  output logic       last_char
);

  localparam logic [1:0] M_COL1 = 2'd0;
  localparam logic [1:0] M_COL2 = 2'd1;
  localparam logic [1:0] M_SEP  = 2'd2;
  localparam logic [1:0] M_DIG  = 2'd3;

  token_t     tok;
  logic       busy;
  logic [2:0] unit;
  logic [1:0] dig;
  logic [1:0] mode;
  logic       out_valid;

  logic       advance;
  logic       emit;
  logic [6:0] ch;
  logic       is_last;
  logic [3:0] unit_inc;
  logic [3:0] n_units;
  logic [3:0] nib;
  logic [15:0] nib_word;

  assign advance  = !out_valid || pop;
  assign emit     = advance && busy;
  assign tok_take = advance && tok_valid && (!busy || is_last);
  assign empty    = !out_valid;
  assign unit_inc = {1'b0, unit} + 4'd1;
  assign n_units  = tok.is_v6 ? 4'(V6_UNITS) : 4'(V4_UNITS);
  assign nib_word = tok.nib[unit];
  assign nib      = nib_word[{dig, 2'b00} +: 4];

  // character and end flag for the current step
  always_comb begin
    ch      = CHAR_COLON;
    is_last = 1'b0;
    unique case (mode)
      M_COL1: begin
        ch = CHAR_COLON;
      end
      M_COL2: begin
        ch      = CHAR_COLON;
        is_last = (tok.run_end == 4'(V6_UNITS));
      end
      M_SEP: begin
        ch = tok.is_v6 ? CHAR_COLON : CHAR_DOT;
      end
      M_DIG: begin
        ch      = (nib < 4'd10) ? CHAR_ZERO + 7'(nib) : CHAR_LOW_A + 7'(nib - 4'd10);
        is_last = (dig == 2'd0) && (unit_inc == n_units);
      end
      default: begin
        ch = CHAR_COLON;
      end
    endcase
  end

  // sequencer over units and digits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mode <= M_DIG;
      unit <= '0;
      dig  <= '0;
    end else if (tok_take) begin
      busy <= 1'b1;
      tok  <= tok_in;
      unit <= '0;
      dig  <= tok_in.top[0];
      mode <= (tok_in.has_run && tok_in.run_start == 3'd0) ? M_COL1 : M_DIG;
    end else if (emit) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        unique case (mode)
          M_COL1: begin
            mode <= M_COL2;
          end
          M_COL2: begin
            unit <= tok.run_end[2:0];
            dig  <= tok.top[tok.run_end[2:0]];
            mode <= M_DIG;
          end
          M_SEP: begin
            mode <= M_DIG;
          end
          M_DIG: begin
            if (dig != 2'd0) begin
              dig <= dig - 2'd1;
            end else begin
              unit <= unit_inc[2:0];
              dig  <= tok.top[unit_inc[2:0]];
              mode <= (tok.has_run && tok.run_start == unit_inc[2:0]) ? M_COL1 : M_SEP;
            end
          end
          default: begin
            mode <= M_DIG;
          end
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      text_char <= ch;
      last_char <= is_last;
    end
  end

endmodule

FILE: tb/tb.sv
module tb;
  import ipatf_pkg::*;

  // one address request as offered to the block
  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic        v6;
  } addr_req_t;

  // one character of predicted text
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    POP_EVERY,
    POP_COIN,
    POP_SPARSE
  } pop_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] addr_high = '0;
  logic [63:0] addr_low = '0;
  logic        is_v6 = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [6:0]  text_char;
  logic        last_char;

  addr_req_t  pending_addrs[$];
  text_char_t expected_text[$];

  int n_items;
  int n_taken;
  int n_v4;
  int n_v6;
  int n_chars;
  int longest_text;
  int errors;

  ip_address_text_formatter dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .addr_high (addr_high),
    .addr_low  (addr_low),
    .is_v6     (is_v6),
    .empty     (empty),
    .pop       (pop),
    .text_char (text_char),
    .last_char (last_char)
  );

  always #5 clk = ~clk;

  // lower-case hex digit
  function automatic logic [6:0] hex_char(input logic [3:0] d);
    return (d < 4'd10) ? CHAR_ZERO + 7'(d) : CHAR_LOW_A + 7'(d - 4'd10);
  endfunction

  // canonical text of one address, appended to the expected characters
  function automatic void format_address(input addr_req_t req);
    logic [6:0]  text[$];
    logic [15:0] grp[8];
    logic [7:0]  octet;
    int          run_at;
    int          run_len;
    int          i;
    int          s;
    int          k;
    int          n;
    logic        need_sep;
    if (!req.v6) begin
      // dotted decimal, no leading zeros
      n_v4++;
      for (i = 3; i >= 0; i--) begin
        octet = req.low[8*i +: 8];
        if (octet >= 8'd100) begin
          text.push_back(CHAR_ZERO + 7'(octet / 100));
          text.push_back(CHAR_ZERO + 7'((octet / 10) % 10));
        end else if (octet >= 8'd10) begin
          text.push_back(CHAR_ZERO + 7'(octet / 10));
        end
        text.push_back(CHAR_ZERO + 7'(octet % 10));
        if (i > 0) text.push_back(CHAR_DOT);
      end
    end else begin
      n_v6++;
      for (i = 0; i < 4; i++) begin
        grp[i]     = req.high[63 - 16*i -: 16];
        grp[i + 4] = req.low[63 - 16*i -: 16];
      end
      // longest zero run of two or more, first one wins a tie
      run_at  = -1;
      run_len = 0;
      i = 0;
      while (i < 8) begin
        if (grp[i] == 16'h0) begin
          s = i;
          while (i < 8 && grp[i] == 16'h0) i++;
          if (i - s >= 2 && i - s > run_len) begin
            run_len = i - s;
            run_at  = s;
          end
        end else begin
          i++;
        end
      end
      // groups in hex, the run collapsed to a double colon
      i = 0;
      need_sep = 1'b0;
      while (i < 8) begin
        if (i == run_at) begin
          text.push_back(CHAR_COLON);
          text.push_back(CHAR_COLON);
          i += run_len;
          need_sep = 1'b0;
        end else begin
          if (need_sep) text.push_back(CHAR_COLON);
          n = 4;
          while (n > 1 && grp[i][4*(n-1) +: 4] == 4'h0) n--;
          for (k = n; k > 0; k--) text.push_back(hex_char(grp[i][4*(k-1) +: 4]));
          need_sep = 1'b1;
          i++;
        end
      end
    end
    if (text.size() > longest_text) longest_text = text.size();
    foreach (text[k]) expected_text.push_back('{ch: text[k], last: (k == text.size() - 1)});
  endfunction

  function automatic void add_v4(input logic [31:0] a, input logic [63:0] junk_hi,
                                 input logic [31:0] junk_lo);
    pending_addrs.push_back('{high: junk_hi, low: {junk_lo, a}, v6: 1'b0});
  endfunction

  function automatic void add_v6(input logic [127:0] a);
    pending_addrs.push_back('{high: a[127:64], low: a[63:0], v6: 1'b1});
  endfunction

  // random group, weighted towards zeros and short groups
  function automatic logic [15:0] rand_group();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'h0;
      4:          return 16'($urandom_range(1, 15));
      5:          return 16'($urandom_range(16, 255));
      6:          return 16'($urandom_range(256, 4095));
      default:    return 16'($urandom);
    endcase
  endfunction

  // random octet covering one, two and three digit values
  function automatic logic [7:0] rand_octet();
    case ($urandom_range(0, 4))
      0:       return 8'h0;
      1:       return 8'($urandom_range(1, 9));
      2:       return 8'($urandom_range(10, 99));
      3:       return 8'($urandom_range(100, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  // sender: bursts of requests separated by random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    addr_req_t req;
    logic      taken;
    if (rst) begin
      push <= 1'b0;
    end else begin
      taken = push && !full;
      if (taken) begin
        format_address('{high: addr_high, low: addr_low, v6: is_v6});
        n_taken++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(0, 1) ? $urandom_range(1, 60) : 0;
        end
      end
      if (push && !taken) begin
        // hold the request until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_addrs.size() > 0) begin
        req = pending_addrs.pop_front();
        addr_high <= req.high;
        addr_low  <= req.low;
        is_v6     <= req.v6;
        push      <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: checks each character and stalls on its own pattern
  pop_mode_e pop_mode = POP_EVERY;
  int        mode_left = 50;
  int        hold_left = 0;
  logic      hold_done = 1'b0;
  int        sparse_phase = 0;
  always @(posedge clk) begin
    text_char_t exp_ch;
    logic       next_pop;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_chars++;
        if (expected_text.size() == 0) begin
          $error("unexpected character %0h (last %0b)", text_char, last_char);
          errors++;
        end else begin
          exp_ch = expected_text.pop_front();
          if (text_char !== exp_ch.ch) begin
            $error("text_char mismatch: expected %0h, got %0h", exp_ch.ch, text_char);
            errors++;
          end
          if (last_char !== exp_ch.last) begin
            $error("last_char mismatch: expected %0b, got %0b", exp_ch.last, last_char);
            errors++;
          end
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (!hold_done && n_taken >= 80) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      mode_left--;
      if (mode_left <= 0) begin
        mode_left = $urandom_range(20, 200);
        pop_mode = pop_mode_e'($urandom_range(0, 2));
      end
      sparse_phase = (sparse_phase + 1) % 4;
      if (hold_left > 0) begin
        hold_left--;
        next_pop = 1'b0;
      end else begin
        case (pop_mode)
          POP_EVERY: next_pop = 1'b1;
          POP_COIN:  next_pop = $urandom_range(0, 1);
          default:   next_pop = (sparse_phase == 0);
        endcase
      end
      pop <= next_pop;
    end
  end

  // stimulus and end of run
  initial begin
    int       i;
    int       s;
    int       len;
    logic [15:0] g[8];
    // ipv4 extremes and digit counts, junk in the ignored bits
    add_v4(32'h00000000, 64'h0, 32'h0);
    add_v4(32'hffffffff, 64'h0, 32'h0);
    add_v4(32'h010a64c8, '1, '1);
    add_v4(32'hc0a80001, 64'hdeadbeef_01234567, 32'h89abcdef);
    add_v4(32'h0a000963, 64'h0, 32'h0);
    // ipv6 all zero and all ones
    add_v6(128'h0);
    add_v6('1);
    // single zero group stays as 0
    add_v6(128'h0001_0000_0002_0003_0004_0005_0006_0007);
    // leading and trailing runs
    add_v6(128'h0000_0000_0000_0000_0000_0000_0000_0001);
    add_v6(128'h0001_0000_0000_0000_0000_0000_0000_0000);
    add_v6(128'h0001_0002_0003_0004_0005_0006_0000_0000);
    add_v6(128'h0000_0000_0001_0002_0003_0004_0005_0006);
    // tie: first run wins; longer later run wins
    add_v6(128'h0001_0000_0000_0002_0003_0000_0000_0004);
    add_v6(128'h0001_0000_0000_0002_0000_0000_0000_0003);
    // leading zeros inside groups, all hex letters
    add_v6(128'h000a_00ab_0abc_abcd_ef01_0f0f_00f0_0def);
    add_v6(128'h2001_0db8_0000_0000_0000_0000_0000_0001);
    // no run at all, alternating zeros
    add_v6(128'h0000_0001_0000_0001_0000_0001_0000_0001);
    // all but one group zero, the nonzero group in the middle or first
    add_v6(128'h0000_0000_0000_ffff_0000_0000_0000_0000);
    add_v6(128'h8000_0000_0000_0000_0000_0000_0000_0000);

    // random part
    for (i = 0; i < 200; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        add_v4({rand_octet(), rand_octet(), rand_octet(), rand_octet()},
               {$urandom, $urandom}, $urandom);
      end else begin
        foreach (g[k]) g[k] = ($urandom_range(0, 5) == 0) ? 16'($urandom) : rand_group();
        if ($urandom_range(0, 2) == 0) begin
          s = $urandom_range(0, 7);
          len = $urandom_range(1, 8 - s);
          for (int k = s; k < s + len; k++) g[k] = 16'h0;
        end
        add_v6({g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7]});
      end
    end
    n_items = pending_addrs.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (n_taken < n_items) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("checked %0d addresses (%0d ipv4, %0d ipv6), %0d characters", n_taken,
             n_v4, n_v6, n_chars);
    $display("longest text %0d characters, one long receiver hold-off applied", longest_text);
    if (errors == 0 && expected_text.size() == 0) begin
      $display("ip_address_text_formatter test passed");
    end else begin
      $display("ip_address_text_formatter test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("ip_address_text_formatter test failed");
    $finish;
  end

endmodule
